### rtl/d6rd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// d6rd_pkg: shared types and constants of the digraph6 record decoder
// Holds the item and result formats, the command passed from the parser to
// the edge walker, the parser states and the header text.
// ----------------------------------------------------------------------------
package d6rd_pkg;

  // Largest graph order that the decoder accepts.
  localparam logic [6:0] MAX_ORDER = 7'd63;

  // Command queue between the parser and the edge walker.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Character codes.
  localparam logic [7:0] CH_AMP  = 8'd38;
  localparam logic [7:0] DATA_LO = 8'd63;
  localparam logic [7:0] DATA_HI = 8'd126;
  localparam logic [3:0] HDR_LEN = 4'd12;

  // Bit positions in one data byte; POS_DONE means all have been walked.
  localparam logic [2:0] POS_DONE = 3'd6;

  typedef enum logic [1:0] {
    KIND_EDGE   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_AMP    = 3'd1,
    ST_INVALID   = 3'd2,
    ST_TRUNCATED = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  typedef enum logic [7:0] {
    PH_SKIP  = 8'b0000_0001,
    PH_HEAD  = 8'b0000_0010,
    PH_AMP   = 8'b0000_0100,
    PH_ORD1  = 8'b0000_1000,
    PH_ORD2  = 8'b0001_0000,
    PH_ORDN  = 8'b0010_0000,
    PH_ADJ   = 8'b0100_0000,
    PH_DRAIN = 8'b1000_0000
  } phase_t;

  // One input item.
  typedef struct packed {
    logic [7:0] rec_byte;
    logic       end_of_record;
  } in_t;

  // One result item.
  typedef struct packed {
    kind_t      kind;
    logic [5:0] edge_src;
    logic [5:0] edge_dst;
    status_t    status;
    logic [5:0] vertex_count;
    logic       last;
  } out_t;

  // Work for the edge walker: up to six adjacency bits, then an optional
  // closing status.
  typedef struct packed {
    logic       has_bits;
    logic [5:0] bits;
    logic [5:0] n;
    logic       has_close;
    status_t    status;
  } cmd_t;

  // Characters of the optional header.
  function automatic logic [7:0] hdr_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0, 4'd1:   c = 8'h3E;
      4'd2:         c = 8'h64;
      4'd3:         c = 8'h69;
      4'd4:         c = 8'h67;
      4'd5:         c = 8'h72;
      4'd6:         c = 8'h61;
      4'd7:         c = 8'h70;
      4'd8:         c = 8'h68;
      4'd9:         c = 8'h36;
      4'd10, 4'd11: c = 8'h3C;
      default:      c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### rtl/d6rd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// d6rd_queue: command queue
// A small first-in first-out queue of commands between the parser and the
// edge walker, so that each side stalls on its own.
// ----------------------------------------------------------------------------
module d6rd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  d6rd_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output d6rd_pkg::cmd_t rd_data,
  output logic           valid
);
  import d6rd_pkg::*;

  cmd_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign full    = (count == (QAW+1)'(QDEPTH));
  assign valid   = (count != '0);
  assign rd_data = mem[rd_ptr];

  // Storage is written on every transfer in.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/d6rd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// d6rd_front: record parser
// Classifies each record byte, tracks the whitespace, header, ampersand and
// order phases, counts the adjacency bits still due and issues one command
// per byte that yields edges or closes the record.
// ----------------------------------------------------------------------------
module d6rd_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  d6rd_pkg::in_t  item,
  output logic           cmd_valid,
  output d6rd_pkg::cmd_t cmd
);
  import d6rd_pkg::*;

  phase_t      phase;
  phase_t      phase_next;
  logic [3:0]  header_index;
  logic [3:0]  header_index_next;
  logic [5:0]  acc_low;
  logic [5:0]  acc_low_next;
  logic        acc_high;
  logic        acc_high_next;
  logic [2:0]  digits_left;
  logic [2:0]  digits_left_next;
  logic [5:0]  order_val;
  logic [5:0]  order_val_next;
  logic [11:0] bits_left;
  logic [11:0] bits_left_next;
  logic        ws_pending;
  logic        ws_pending_next;

  logic [7:0]  b;
  logic [7:0]  diff;
  logic [5:0]  digit;
  logic        is_ws;
  logic        is_data;
  logic        fin;
  logic [5:0]  fin_low;
  logic        fin_high;
  logic        close;
  status_t     close_st;

  assign b     = item.rec_byte;
  assign diff  = b - DATA_LO;
  assign digit = diff[5:0];

  // Byte classes.
  always_comb begin
    is_ws   = b inside {[8'd9:8'd13], 8'd32};
    is_data = b inside {[DATA_LO:DATA_HI]};
  end

  // Parser next state and command.
  always_comb begin
    phase_next        = phase;
    header_index_next = header_index;
    acc_low_next      = acc_low;
    acc_high_next     = acc_high;
    digits_left_next  = digits_left;
    order_val_next    = order_val;
    bits_left_next    = bits_left;
    ws_pending_next   = ws_pending;
    fin               = 1'b0;
    fin_low           = acc_low;
    fin_high          = acc_high;
    close             = 1'b0;
    close_st          = ST_OK;
    cmd               = '0;
    cmd.n             = order_val;

    case (phase)
      PH_SKIP: begin
        if (!is_ws) begin
          if (b == CH_AMP) begin
            phase_next = PH_ORD1;
          end else if (b == hdr_char(4'd0)) begin
            header_index_next = 4'd1;
            phase_next        = PH_HEAD;
          end else begin
            close    = 1'b1;
            close_st = ST_NO_AMP;
          end
        end
      end
      PH_HEAD: begin
        if (header_index < HDR_LEN && b == hdr_char(header_index)) begin
          header_index_next = header_index + 4'd1;
          if (header_index_next == HDR_LEN) begin
            phase_next = PH_AMP;
          end
        end else begin
          close    = 1'b1;
          close_st = ST_NO_AMP;
        end
      end
      PH_AMP: begin
        if (b == CH_AMP) begin
          phase_next = PH_ORD1;
        end else begin
          close    = 1'b1;
          close_st = ST_NO_AMP;
        end
      end
      PH_ORD1, PH_ORD2, PH_ORDN, PH_ADJ: begin
        if (is_ws) begin
          ws_pending_next = 1'b1;
        end else if (ws_pending || !is_data) begin
          close    = 1'b1;
          close_st = ST_INVALID;
        end else if (phase == PH_ORD1) begin
          // Short form, or the escape to the longer forms.
          if (b == DATA_HI) begin
            phase_next = PH_ORD2;
          end else begin
            fin      = 1'b1;
            fin_low  = digit;
            fin_high = 1'b0;
          end
        end else if (phase == PH_ORD2) begin
          if (b == DATA_HI) begin
            acc_low_next     = '0;
            digits_left_next = 3'd6;
          end else begin
            acc_low_next     = digit;
            digits_left_next = 3'd2;
          end
          acc_high_next = 1'b0;
          phase_next    = PH_ORDN;
        end else if (phase == PH_ORDN) begin
          // Only whether the upper digits are all zero matters.
          fin_low          = digit;
          fin_high         = acc_high | (acc_low != '0);
          acc_low_next     = fin_low;
          acc_high_next    = fin_high;
          digits_left_next = digits_left - 3'd1;
          if (digits_left_next == '0) begin
            fin = 1'b1;
          end
        end else begin
          // Adjacency byte: the last one masks the bits past the matrix.
          cmd.has_bits = 1'b1;
          if (bits_left <= 12'd6) begin
            cmd.bits = digit & ~(6'h3F >> bits_left[2:0]);
            close    = 1'b1;
            close_st = ST_OK;
          end else begin
            cmd.bits       = digit;
            bits_left_next = bits_left - 12'd6;
          end
        end
      end
      default: begin
      end
    endcase

    // Order complete: check its range and load the bit count.
    if (fin) begin
      if (!fin_high && fin_low != '0 && {1'b0, fin_low} <= MAX_ORDER) begin
        order_val_next = fin_low;
        bits_left_next = {6'd0, fin_low} * {6'd0, fin_low};
        phase_next     = PH_ADJ;
      end else begin
        close    = 1'b1;
        close_st = ST_RANGE;
      end
    end

    if (close) begin
      phase_next = PH_DRAIN;
    end

    // End of record closes anything still open and clears for the next one.
    if (item.end_of_record) begin
      if (phase_next == PH_SKIP || phase_next == PH_HEAD || phase_next == PH_AMP) begin
        close    = 1'b1;
        close_st = ST_NO_AMP;
      end else if (phase_next != PH_DRAIN) begin
        close    = 1'b1;
        close_st = ST_TRUNCATED;
      end
      phase_next        = PH_SKIP;
      header_index_next = '0;
      acc_low_next      = '0;
      acc_high_next     = 1'b0;
      digits_left_next  = '0;
      order_val_next    = '0;
      bits_left_next    = '0;
      ws_pending_next   = 1'b0;
    end

    cmd.has_close = close;
    cmd.status    = close_st;
    cmd_valid     = accept && (close || cmd.has_bits);
  end

  // Parser registers advance on each transfer in.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SKIP;
      header_index <= '0;
      acc_low      <= '0;
      acc_high     <= 1'b0;
      digits_left  <= '0;
      order_val    <= '0;
      bits_left    <= '0;
      ws_pending   <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      header_index <= header_index_next;
      acc_low      <= acc_low_next;
      acc_high     <= acc_high_next;
      digits_left  <= digits_left_next;
      order_val    <= order_val_next;
      bits_left    <= bits_left_next;
      ws_pending   <= ws_pending_next;
    end
  end

endmodule

### rtl/d6rd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// d6rd_back: edge walker
// Takes commands from the queue, walks their adjacency bits one position a
// cycle with row and column counters, and delivers edges and the closing
// status through an output register; a set bit waits while it is held.
// ----------------------------------------------------------------------------
module d6rd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  d6rd_pkg::cmd_t q_cmd,
  output logic           q_pop,
  input  logic           pop,
  output logic           empty,
  output d6rd_pkg::out_t result
);
  import d6rd_pkg::*;

  logic       cur_valid;
  cmd_t       cur;
  logic [5:0] sh;
  logic [2:0] pos;
  logic [2:0] pos_next;
  logic [5:0] row;
  logic [5:0] row_next;
  logic [5:0] col;
  logic [5:0] col_next;
  logic       out_valid;

  logic       can_load;
  logic       step;
  logic       emit;
  logic       finish;
  logic [6:0] col_inc;
  out_t       res;

  assign empty = !out_valid;

  // One bit position or the closing status per cycle; a set bit or a status waits for a free output register.
  always_comb begin
    can_load = !out_valid || pop;
    step     = 1'b0;
    emit     = 1'b0;
    finish   = 1'b0;
    res      = '0;
    pos_next = pos;
    row_next = row;
    col_next = col;
    col_inc  = {1'b0, col} + 7'd1;

    if (cur_valid) begin
      if (pos != POS_DONE) begin
        if (!sh[5] || can_load) begin
          step         = 1'b1;
          emit         = sh[5];
          res.kind     = KIND_EDGE;
          res.edge_src = row;
          res.edge_dst = col;
          pos_next     = pos + 3'd1;
          if (col_inc >= {1'b0, cur.n}) begin
            col_next = '0;
            row_next = row + 6'd1;
          end else begin
            col_next = col_inc[5:0];
          end
          // A command without a closing status is done with its last bit.
          if (pos == 3'd5 && !cur.has_close) begin
            finish = 1'b1;
          end
        end
      end else if (!cur.has_close) begin
        finish = 1'b1;
      end else if (can_load) begin
        emit     = 1'b1;
        finish   = 1'b1;
        res.last = 1'b1;
        if (cur.status == ST_OK) begin
          res.kind         = KIND_ACCEPT;
          res.vertex_count = cur.n;
        end else begin
          res.kind   = KIND_REJECT;
          res.status = cur.status;
        end
        row_next = '0;
        col_next = '0;
      end
    end

    q_pop = q_valid && (!cur_valid || finish);
  end

  // Current command, bit shifter and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      pos       <= '0;
      row       <= '0;
      col       <= '0;
    end else begin
      row <= row_next;
      col <= col_next;
      if (q_pop) begin
        cur_valid <= 1'b1;
        pos       <= q_cmd.has_bits ? 3'd0 : POS_DONE;
      end else if (finish) begin
        cur_valid <= 1'b0;
      end else begin
        pos <= pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_cmd;
      sh  <= q_cmd.bits;
    end else if (step) begin
      sh <= {sh[4:0], 1'b0};
    end
  end

  // Output register: loads when free or when its result transfers out.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= res;
    end
  end

endmodule

### rtl/digraph6_record_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// digraph6_record_decoder: digraph6 record decoder
// Decodes a textual digraph6 record, one byte per transfer, into edge
// results and one closing status per record.
// ----------------------------------------------------------------------------
// The parser takes one byte per cycle whenever the four-entry command queue
// has room, so full rises only when the edge walker falls behind. The walker
// steps through each adjacency byte one bit position per cycle, whether or
// not the bit is set, and then delivers any closing status; header, order
// and whitespace bytes cost it nothing. Sustained throughput on adjacency
// bytes is therefore set by the walker's bit loop, with one byte per cycle
// elsewhere while the queue has room. A result stays on the result ports until
// popped; a waiting result stalls the walker only when it has another one to
// deliver.
// ----------------------------------------------------------------------------
module digraph6_record_decoder (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  d6rd_pkg::in_t  item,
  output logic           empty,
  input  logic           pop,
  output d6rd_pkg::out_t result
);
  import d6rd_pkg::*;

  logic accept;
  logic cmd_valid;
  cmd_t cmd;
  logic q_full;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  assign full   = q_full;
  assign accept = push && !full;

  d6rd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  d6rd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_valid),
    .wr_data (cmd),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_cmd),
    .valid   (q_valid)
  );

  d6rd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

### rtl/d6rd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// d6rd_checker: port checks for the digraph6 record decoder
// Watches the top-level ports and flags results that break the format.
// ----------------------------------------------------------------------------
module d6rd_checker (
  input logic           clk,
  input logic           rst,
  input logic           empty,
  input logic           pop,
  input d6rd_pkg::out_t result
);
  import d6rd_pkg::*;

  // Nothing is offered right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result offered right after reset");

  // A result that is not taken holds still.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("waiting result changed before its transfer");

  // Only a status result closes a record.
  a_last: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.last == (result.kind != KIND_EDGE)))
    else $error("last flag does not match the result kind");

  // An accepted record reports a real order and an ok status.
  a_accept: assert property (@(posedge clk) disable iff (rst)
    !empty && result.kind == KIND_ACCEPT |->
      result.vertex_count != 6'd0 && result.status == ST_OK)
    else $error("accepted status with bad order or status code");

  // Edges stay inside the largest matrix and carry no status.
  a_edge: assert property (@(posedge clk) disable iff (rst)
    !empty && result.kind == KIND_EDGE |->
      result.edge_src != 6'd63 && result.edge_dst != 6'd63 &&
      result.status == ST_OK && result.vertex_count == 6'd0)
    else $error("edge result out of range");

endmodule

bind digraph6_record_decoder d6rd_checker u_checker (.*);

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the digraph6 record decoder
// Pushes a short table of directed records and then random records, one byte
// per transfer, with bursty pushes and patterned pops. A software decoder
// kept in step with every accepted byte predicts the edges and the closing
// status of each record, and every popped result is checked against it.
// ----------------------------------------------------------------------------
module tb_top;
  import d6rd_pkg::*;

  localparam int          ITEM_GOAL     = 450;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          MAX_REPORTS   = 10;
  localparam longint      TIMEOUT_NS    = 64'd10_000_000;
  localparam logic [95:0] HDR_TEXT      = ">>digraph6<<";

  // One row of the directed table; typed rows carry their single result.
  typedef struct packed {
    logic [7:0] b;
    logic       eor;
    logic       typed;
    out_t       want;
  } stim_row_t;

  localparam out_t NO_WANT     = '0;
  localparam out_t REJ_NO_AMP  = '{KIND_REJECT, 6'd0, 6'd0, ST_NO_AMP, 6'd0, 1'b1};
  localparam out_t REJ_INVALID = '{KIND_REJECT, 6'd0, 6'd0, ST_INVALID, 6'd0, 1'b1};
  localparam out_t REJ_TRUNC   = '{KIND_REJECT, 6'd0, 6'd0, ST_TRUNCATED, 6'd0, 1'b1};
  localparam out_t REJ_RANGE   = '{KIND_REJECT, 6'd0, 6'd0, ST_RANGE, 6'd0, 1'b1};

  localparam int NUM_DIRECTED = 27;
  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    // Leading blank, then a stray letter.
    '{8'h20, 1'b0, 1'b0, NO_WANT},
    '{"A",   1'b1, 1'b1, REJ_NO_AMP},
    // A record of whitespace only.
    '{8'h09, 1'b1, 1'b1, REJ_NO_AMP},
    // Byte extremes at the start of a record.
    '{8'hFF, 1'b1, 1'b1, REJ_NO_AMP},
    '{8'h00, 1'b0, 1'b1, REJ_NO_AMP},
    // Ignored byte after the record is decided.
    '{8'h7E, 1'b1, 1'b0, NO_WANT},
    // Full header, then a one-vertex graph with a self loop.
    '{">",   1'b0, 1'b0, NO_WANT},
    '{">",   1'b0, 1'b0, NO_WANT},
    '{"d",   1'b0, 1'b0, NO_WANT},
    '{"i",   1'b0, 1'b0, NO_WANT},
    '{"g",   1'b0, 1'b0, NO_WANT},
    '{"r",   1'b0, 1'b0, NO_WANT},
    '{"a",   1'b0, 1'b0, NO_WANT},
    '{"p",   1'b0, 1'b0, NO_WANT},
    '{"h",   1'b0, 1'b0, NO_WANT},
    '{"6",   1'b0, 1'b0, NO_WANT},
    '{"<",   1'b0, 1'b0, NO_WANT},
    '{"<",   1'b0, 1'b0, NO_WANT},
    '{"&",   1'b0, 1'b0, NO_WANT},
    '{"@",   1'b0, 1'b0, NO_WANT},
    '{8'h7E, 1'b1, 1'b0, NO_WANT},
    // Record ends before the order.
    '{"&",   1'b1, 1'b1, REJ_TRUNC},
    // Order of zero.
    '{"&",   1'b0, 1'b0, NO_WANT},
    '{"?",   1'b1, 1'b1, REJ_RANGE},
    // Inner whitespace followed by a data byte.
    '{"&",   1'b0, 1'b0, NO_WANT},
    '{8'h20, 1'b0, 1'b0, NO_WANT},
    '{"@",   1'b1, 1'b1, REJ_INVALID}
  };

  logic clk  = 1'b0;
  logic rst  = 1'b1;
  logic push = 1'b0;
  logic full;
  in_t  item = '0;
  logic empty;
  logic pop  = 1'b0;
  out_t result;

  // Decoder state mirrored in software.
  phase_t      dec_phase;
  int unsigned dec_hdr_idx;
  logic [35:0] dec_order;
  int unsigned dec_digits;
  logic [5:0]  dec_nverts;
  logic [5:0]  dec_row;
  logic [5:0]  dec_col;
  logic        dec_ws_pending;

  out_t step_out[$];
  out_t due_results[$];
  int   mismatches    = 0;
  int   counted_items = 0;
  int   burst_left    = 0;
  int   rx_tick       = 0;

  // Clock generation.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  digraph6_record_decoder u_top (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  function automatic logic is_space(input logic [7:0] b);
    return (b >= 8'd9 && b <= 8'd13) || b == 8'd32;
  endfunction

  function automatic logic [7:0] pick_space();
    logic [7:0] b;
    b = 8'($urandom_range(8, 13));
    return (b == 8'd8) ? 8'd32 : b;
  endfunction

  function automatic void clear_record();
    dec_hdr_idx    = 0;
    dec_order      = '0;
    dec_digits     = 0;
    dec_nverts     = '0;
    dec_row        = '0;
    dec_col        = '0;
    dec_ws_pending = 1'b0;
  endfunction

  // Emits the closing status; the rest of the record is then ignored.
  function automatic void close_record(input status_t st);
    out_t r;
    r = '0;
    if (st == ST_OK) begin
      r.kind         = KIND_ACCEPT;
      r.vertex_count = dec_nverts;
    end else begin
      r.kind = KIND_REJECT;
    end
    r.status = st;
    r.last   = 1'b1;
    step_out.push_back(r);
    dec_phase = PH_DRAIN;
  endfunction

  // The order is range checked only once all of its bytes are in.
  function automatic void finish_order();
    if (dec_order < 36'd1 || dec_order > MAX_ORDER) begin
      close_record(ST_RANGE);
    end else begin
      dec_nverts = dec_order[5:0];
      dec_row    = '0;
      dec_col    = '0;
      dec_phase  = PH_ADJ;
    end
  endfunction

  // Advances the software decoder by one byte; the results land in step_out.
  function automatic void decode_byte(input in_t it);
    logic [7:0] b;
    logic [5:0] digit;
    out_t       e;
    b     = it.rec_byte;
    digit = 6'(b - DATA_LO);
    step_out.delete();
    case (dec_phase)
      PH_SKIP: begin
        if (!is_space(b)) begin
          if (b == CH_AMP) begin
            dec_phase = PH_ORD1;
          end else if (b == HDR_TEXT[95 -: 8]) begin
            dec_hdr_idx = 1;
            dec_phase   = PH_HEAD;
          end else begin
            close_record(ST_NO_AMP);
          end
        end
      end
      PH_HEAD: begin
        if (b == HDR_TEXT[95 - 8 * dec_hdr_idx -: 8]) begin
          dec_hdr_idx++;
          if (dec_hdr_idx == HDR_LEN) dec_phase = PH_AMP;
        end else begin
          close_record(ST_NO_AMP);
        end
      end
      PH_AMP: begin
        if (b == CH_AMP) dec_phase = PH_ORD1;
        else close_record(ST_NO_AMP);
      end
      PH_ORD1, PH_ORD2, PH_ORDN, PH_ADJ: begin
        if (is_space(b)) begin
          dec_ws_pending = 1'b1;
        end else if (dec_ws_pending || b < DATA_LO || b > DATA_HI) begin
          close_record(ST_INVALID);
        end else begin
          case (dec_phase)
            PH_ORD1: begin
              if (b == DATA_HI) begin
                dec_phase = PH_ORD2;
              end else begin
                dec_order = 36'(digit);
                finish_order();
              end
            end
            PH_ORD2: begin
              if (b == DATA_HI) begin
                dec_order  = '0;
                dec_digits = 6;
              end else begin
                dec_order  = 36'(digit);
                dec_digits = 2;
              end
              dec_phase = PH_ORDN;
            end
            PH_ORDN: begin
              dec_order = {dec_order[29:0], digit};
              if (dec_digits > 0) dec_digits--;
              if (dec_digits == 0) finish_order();
            end
            default: begin
              // Six adjacency bits, MSB first, in row-major order.
              for (int sh = 5; sh >= 0; sh--) begin
                if (digit[sh]) begin
                  e = '{KIND_EDGE, dec_row, dec_col, ST_OK, 6'd0, 1'b0};
                  step_out.push_back(e);
                end
                dec_col++;
                if (dec_col >= dec_nverts) begin
                  dec_col = '0;
                  dec_row++;
                  if (dec_row >= dec_nverts) begin
                    close_record(ST_OK);
                    break;
                  end
                end
              end
            end
          endcase
        end
      end
      default: ;
    endcase

    // End of record closes whatever is still open.
    if (it.end_of_record) begin
      if (dec_phase == PH_SKIP || dec_phase == PH_HEAD || dec_phase == PH_AMP) begin
        close_record(ST_NO_AMP);
      end else if (dec_phase != PH_DRAIN) begin
        close_record(ST_TRUNCATED);
      end
      dec_phase = PH_SKIP;
      clear_record();
    end
  endfunction

  // Pushes one byte in bursts with random gaps and records what it should cause.
  task automatic send_byte(input logic [7:0] b, input logic eor,
                           input logic typed = 1'b0, input out_t want = '0);
    in_t it;
    int  gap;
    it.rec_byte      = b;
    it.end_of_record = eor;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    counted_items++;
    decode_byte(it);
    if (typed) begin
      due_results.push_back(want);
    end else begin
      foreach (step_out[i]) due_results.push_back(step_out[i]);
    end
    burst_left--;
  endtask

  // Builds one random record: mostly well formed, some broken, some noise.
  task automatic send_record();
    logic [7:0]  rec[$];
    logic [35:0] nval;
    int          pick;
    int          form;
    int          ndata;
    int          pos;
    pick = $urandom_range(0, 99);
    if (pick >= 90) begin
      repeat ($urandom_range(1, 6)) rec.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) rec.push_back(pick_space());
      if ($urandom_range(0, 3) == 0) begin
        for (int i = 0; i < 12; i++) rec.push_back(HDR_TEXT[95 - 8 * i -: 8]);
      end
      rec.push_back(CH_AMP);

      // Order value: mostly small, rarely large, and some out of range.
      if (pick >= 80) begin
        case ($urandom_range(0, 2))
          0:       nval = '0;
          1:       nval = 36'(64 + $urandom_range(0, 1000));
          default: nval = {4'($urandom), 32'($urandom)};
        endcase
        ndata = $urandom_range(0, 2);
      end else begin
        if ($urandom_range(0, 49) == 0) begin
          nval = ($urandom_range(0, 1) == 0) ? 36'd63 : 36'($urandom_range(1, 63));
        end else begin
          nval = 36'($urandom_range(1, 8));
        end
        ndata = (int'(nval) * int'(nval) + 5) / 6;
      end

      // Short, medium or long form, whichever the value fits.
      form = $urandom_range(0, 2);
      if (form == 0 && nval > 36'd62) form = 1;
      if (form == 1 && nval >= 36'd258048) form = 2;
      case (form)
        0: rec.push_back(DATA_LO + {2'b00, nval[5:0]});
        1: begin
          rec.push_back(DATA_HI);
          for (int i = 0; i < 3; i++) rec.push_back(DATA_LO + {2'b00, nval[17 - 6 * i -: 6]});
        end
        default: begin
          rec.push_back(DATA_HI);
          rec.push_back(DATA_HI);
          for (int i = 0; i < 6; i++) rec.push_back(DATA_LO + {2'b00, nval[35 - 6 * i -: 6]});
        end
      endcase
      repeat (ndata) rec.push_back(DATA_LO + 8'($urandom_range(0, 63)));
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) rec.push_back(8'($urandom_range(0, 255)));
      end

      // Break some records: cut short, stray whitespace, or a bad byte.
      if (pick >= 70 && pick < 80) begin
        pos = $urandom_range(1, rec.size() - 1);
        case ($urandom_range(0, 2))
          0:       while (rec.size() > pos) void'(rec.pop_back());
          1:       rec.insert(pos, pick_space());
          default: rec[pos] = 8'($urandom_range(0, 255));
        endcase
      end
    end
    foreach (rec[i]) send_byte(rec[i], i == rec.size() - 1);
  endtask

  // Result side: check each transfer, then choose the next pop.
  always @(posedge clk) begin
    out_t want;
    if (!rst && pop && !empty) begin
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("Unexpected result: kind=%0d src=%0d dst=%0d status=%0d count=%0d last=%0d",
                   result.kind, result.edge_src, result.edge_dst, result.status,
                   result.vertex_count, result.last);
        end
      end else begin
        want = due_results.pop_front();
        if (result.kind !== want.kind || result.edge_src !== want.edge_src ||
            result.edge_dst !== want.edge_dst || result.status !== want.status ||
            result.vertex_count !== want.vertex_count || result.last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("Mismatch: expected kind=%0d src=%0d dst=%0d status=%0d count=%0d last=%0d",
                     want.kind, want.edge_src, want.edge_dst, want.status,
                     want.vertex_count, want.last);
            $display("          got      kind=%0d src=%0d dst=%0d status=%0d count=%0d last=%0d",
                     result.kind, result.edge_src, result.edge_dst, result.status,
                     result.vertex_count, result.last);
          end
        end
      end
    end

    // Pop pattern rotates with rx_tick bits 8 and 7: free, random, sparse, periodic.
    rx_tick++;
    case (rx_tick[8:7])
      2'd0:    pop <= 1'b1;
      2'd1:    pop <= 1'($urandom_range(0, 1));
      2'd2:    pop <= ($urandom_range(0, 3) == 0);
      default: pop <= (rx_tick[3:0] >= 4'd10);
    endcase
  end

  // Main sequence: reset, directed table, random records, drain.
  initial begin
    dec_phase = PH_SKIP;
    clear_record();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_byte(DIRECTED[i].b, DIRECTED[i].eor, DIRECTED[i].typed, DIRECTED[i].want);
    end
    while (counted_items < ITEM_GOAL) send_record();
    push <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hang guard, well beyond the slowest legal run.
  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

endmodule
